// File: src/text_terminal_char_writer_unit_assert.svh
// Assertion macros for the text terminal character writer.
`ifndef TEXT_TERMINAL_CHAR_WRITER_UNIT_ASSERT_SVH
`define TEXT_TERMINAL_CHAR_WRITER_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define TTCW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ttcw same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define TTCW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ttcw next-cycle check failed");

`endif

// File: src/ttcw_pkg.sv
// Shared types and constants of the text terminal character writer.
`timescale 1ns / 1ps
`default_nettype none

package ttcw_pkg;

    localparam int COL_W       = 7;
    localparam int ROW_W       = 5;
    localparam int CELL_W      = 16;
    localparam int POS_W       = 11;
    localparam int LIN_W       = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]        NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]        BLANK_CHAR   = 8'h20;
    localparam logic [7:0]        ATTR_RESET   = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;

    // Command kinds decided by the front end
    typedef enum logic [1:0] {
        K_PUT       = 2'd0,
        K_NEWLINE   = 2'd1,
        K_READ      = 2'd2,
        K_READ_NULL = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        char_code;
        logic [COL_W-1:0]  read_column;
        logic [ROW_W-1:0]  read_row;
        logic [7:0]        attr;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

`default_nettype wire

// File: src/ttcw_front.sv
// Front end: attribute register, input handshake and command classification.
`timescale 1ns / 1ps
`default_nettype none

module ttcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [7:0]               i_cfg_wdata,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_action,
    input  wire logic [7:0]               i_char_code,
    input  wire logic [6:0]               i_read_column,
    input  wire logic [4:0]               i_read_row,
    input  wire logic                     i_fifo_full,
    input  wire ttcw_pkg::t_back_status   i_status,
    output ttcw_pkg::t_push               o_push
);
    import ttcw_pkg::*;

    localparam logic [COL_W:0] COL_LIMIT = (COL_W+1)'(COLUMNS);
    localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W+1)'(ROWS);

    logic [7:0] r_attr;
    logic       w_in_range;

    // Hold the attribute for new characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    // Stall while the queue is full or the screen is being cleared after reset
    assign o_in_ready = !i_fifo_full && !i_status.init_busy;

    assign w_in_range = ({1'b0, i_read_column} < COL_LIMIT) &&
                        ({1'b0, i_read_row} < ROW_LIMIT);

    // Classify the transaction and capture the attribute with it
    always_comb begin
        o_push.valid           = i_in_valid && o_in_ready;
        o_push.cmd.char_code   = i_char_code;
        o_push.cmd.read_column = i_read_column;
        o_push.cmd.read_row    = i_read_row;
        o_push.cmd.attr        = r_attr;
        if (i_action) begin
            o_push.cmd.kind = w_in_range ? K_READ : K_READ_NULL;
        end else if (i_char_code == NEWLINE_CODE) begin
            o_push.cmd.kind = K_NEWLINE;
        end else begin
            o_push.cmd.kind = K_PUT;
        end
    end

endmodule

`default_nettype wire

// File: src/ttcw_cmd_fifo.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module ttcw_cmd_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ttcw_pkg::t_push  i_push,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic                  o_full,
    output ttcw_pkg::t_cmd        o_head
);
    import ttcw_pkg::*;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QPTR_W:0]   CNT_FULL = (QPTR_W+1)'(QUEUE_DEPTH);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W-1:0] n_wptr;
    logic [QPTR_W-1:0] n_rptr;
    logic [QPTR_W:0]   n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_head  = r_slot[r_rptr];

    // Advance pointers and count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push.valid) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push.valid && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wptr] <= i_push.cmd;
        end
    end

endmodule

`default_nettype wire

// File: src/ttcw_back.sv
// Back end: screen memory, cursor, scroll ring and result register.
`timescale 1ns / 1ps
`default_nettype none

module ttcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_empty,
    input  wire ttcw_pkg::t_cmd      i_head,
    output logic                     o_pop,
    output ttcw_pkg::t_back_status   o_status,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [15:0]              o_cell_value,
    output logic [6:0]               o_cursor_column,
    output logic [4:0]               o_cursor_row,
    output logic [10:0]              o_cursor_position
);
    import ttcw_pkg::*;

    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [ADDR_W-1:0] A_COLS    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] A_LAST    = ADDR_W'(DEPTH - 1);
    localparam logic [COL_W:0]    COL_LIMIT = (COL_W+1)'(COLUMNS);
    localparam logic [ROW_W:0]    ROW_LIMIT = (ROW_W+1)'(ROWS);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [LIN_W-1:0]  L_COLS    = LIN_W'(COLUMNS);

    typedef enum logic [3:0] {
        ST_INIT   = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_RDWAIT = 4'b0100,
        ST_SCROLL = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [ROW_W-1:0]   r_top, n_top;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0]  r_clr_end, n_clr_end;
    logic [CELL_W-1:0]  r_clr_data, n_clr_data;
    logic [CELL_W-1:0]  r_screen [DEPTH];
    logic [CELL_W-1:0]  r_rdata;
    logic               r_out_valid;
    logic [CELL_W-1:0]  r_out_cell;
    logic [COL_W-1:0]   r_out_col;
    logic [ROW_W-1:0]   r_out_row;
    logic [POS_W-1:0]   r_out_pos;

    logic               w_slot_free;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [CELL_W-1:0]  w_wdata;
    logic               w_re;
    logic [ADDR_W-1:0]  w_raddr;
    logic               w_wrap;
    logic [COL_W:0]     w_col_inc;
    logic [ADDR_W-1:0]  w_row_base;
    logic               w_out_load;
    logic [LIN_W-1:0]   w_lin_pos;

    // Map a screen row to its place in the ring of stored rows
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= ROW_LIMIT) begin
            sum = sum - ROW_LIMIT;
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] top);
        return ADDR_W'(ADDR_W'(phys_row(row, top)) * A_COLS) + ADDR_W'(col);
    endfunction

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_pop       = (r_state == ST_IDLE) && !i_empty && w_slot_free;
    assign w_col_inc   = {1'b0, r_col} + 1'b1;
    assign w_row_base  = ADDR_W'(ADDR_W'(r_top) * A_COLS);
    assign w_raddr     = cell_addr(i_head.read_row, i_head.read_column, r_top);

    // Sequence clears, writes, reads and cursor moves
    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_top      = r_top;
        n_clr_addr = r_clr_addr;
        n_clr_end  = r_clr_end;
        n_clr_data = r_clr_data;
        w_we       = 1'b0;
        w_waddr    = r_clr_addr;
        w_wdata    = r_clr_data;
        w_re       = 1'b0;
        w_wrap     = 1'b0;
        case (r_state)
            ST_INIT, ST_SCROLL: begin
                w_we = 1'b1;
                if (r_clr_addr == r_clr_end) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (o_pop) begin
                    case (i_head.kind)
                        K_PUT: begin
                            w_we    = 1'b1;
                            w_waddr = cell_addr(r_row, r_col, r_top);
                            w_wdata = {i_head.attr, i_head.char_code};
                            if (w_col_inc == COL_LIMIT) begin
                                w_wrap = 1'b1;
                            end else begin
                                n_col = w_col_inc[COL_W-1:0];
                            end
                        end
                        K_NEWLINE: begin
                            w_wrap = 1'b1;
                        end
                        K_READ: begin
                            w_re    = 1'b1;
                            n_state = ST_RDWAIT;
                        end
                        default: begin
                        end
                    endcase
                    // Next row; past the last row, rotate the ring and blank the old top
                    if (w_wrap) begin
                        n_col = '0;
                        if (r_row == ROW_LAST) begin
                            n_top      = (r_top == ROW_LAST) ? '0 : r_top + 1'b1;
                            n_clr_addr = w_row_base;
                            n_clr_end  = w_row_base + A_COLS - 1'b1;
                            n_clr_data = {i_head.attr, BLANK_CHAR};
                            n_state    = ST_SCROLL;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end
                end
            end
            ST_RDWAIT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_col      <= '0;
            r_row      <= '0;
            r_top      <= '0;
            r_clr_addr <= '0;
            r_clr_end  <= A_LAST;
            r_clr_data <= RESET_CELL;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_top      <= n_top;
            r_clr_addr <= n_clr_addr;
            r_clr_end  <= n_clr_end;
            r_clr_data <= n_clr_data;
        end
    end

    // Screen memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_screen[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_screen[w_raddr];
        end
    end

    // Load the result register when an item finishes
    assign w_out_load = (o_pop && (i_head.kind != K_READ)) || (r_state == ST_RDWAIT);
    assign w_lin_pos  = LIN_W'(LIN_W'(n_row) * L_COLS) + LIN_W'(n_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_cell <= (r_state == ST_RDWAIT) ? r_rdata : '0;
            r_out_col  <= n_col;
            r_out_row  <= n_row;
            r_out_pos  <= w_lin_pos[POS_W-1:0];
        end
    end

    assign o_status.init_busy = (r_state == ST_INIT);
    assign o_out_valid        = r_out_valid;
    assign o_cell_value       = r_out_cell;
    assign o_cursor_column    = r_out_col;
    assign o_cursor_row       = r_out_row;
    assign o_cursor_position  = r_out_pos;

endmodule

`default_nettype wire

// File: src/text_terminal_char_writer_unit.sv
// Flow: an accepted put, newline or out-of-range read is stored in the command queue,
// popped by the back end and loaded into the result register; an in-range read also
// waits in ST_RDWAIT for the registered screen memory read port. The back end takes one
// put or newline per cycle while the result register is free; a scroll past the last row
// holds it while it blanks one row of the ring. Reset: cursor at 0,0, attribute 7;
// the screen is then filled with 0x0720, and no input is accepted until that ends.
`timescale 1ns / 1ps
`default_nettype none
`include "text_terminal_char_writer_unit_assert.svh"

module text_terminal_char_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [6:0]  i_read_column,
    input  wire logic [4:0]  i_read_row,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_cell_value,
    output logic [6:0]       o_cursor_column,
    output logic [4:0]       o_cursor_row,
    output logic [10:0]      o_cursor_position
);
    import ttcw_pkg::*;

    localparam logic [COL_W:0] COL_LIMIT = (COL_W+1)'(COLUMNS);
    localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W+1)'(ROWS);

    t_push        w_push;
    t_cmd         w_head;
    t_back_status w_status;
    logic         w_fifo_full;
    logic         w_fifo_empty;
    logic         w_pop;

    ttcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_char_code   (i_char_code),
        .i_read_column (i_read_column),
        .i_read_row    (i_read_row),
        .i_fifo_full   (w_fifo_full),
        .i_status      (w_status),
        .o_push        (w_push)
    );

    ttcw_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_empty (w_fifo_empty),
        .o_full  (w_fifo_full),
        .o_head  (w_head)
    );

    ttcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (w_fifo_empty),
        .i_head            (w_head),
        .o_pop             (w_pop),
        .o_status          (w_status),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_cell_value      (o_cell_value),
        .o_cursor_column   (o_cursor_column),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_position (o_cursor_position)
    );

    // Checks
    `TTCW_ASSERT_IMP(a_no_accept_in_init, w_status.init_busy, !o_in_ready)
    `TTCW_ASSERT_IMP(a_no_push_when_full, w_push.valid, !w_fifo_full)
    `TTCW_ASSERT_NXT(a_init_runs_once, !w_status.init_busy, !w_status.init_busy)
    `TTCW_ASSERT_IMP(a_cursor_in_screen, o_out_valid, ({1'b0, o_cursor_column} < COL_LIMIT) && ({1'b0, o_cursor_row} < ROW_LIMIT))

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the text terminal character writer.
`timescale 1ns / 1ps

module tb_top;

    import ttcw_pkg::*;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int SETTLE_CYC = COLUMNS + 8;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_position;
    } t_term_result;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_cfg_we          = 1'b0;
    logic [7:0]  i_cfg_wdata       = 8'h00;
    logic        i_in_valid        = 1'b0;
    logic        o_in_ready;
    logic        i_action          = ACT_PUT;
    logic [7:0]  i_char_code       = 8'h00;
    logic [6:0]  i_read_column     = 7'd0;
    logic [4:0]  i_read_row        = 5'd0;
    logic        o_out_valid;
    logic        i_out_ready       = 1'b0;
    logic [15:0] o_cell_value;
    logic [6:0]  o_cursor_column;
    logic [4:0]  o_cursor_row;
    logic [10:0] o_cursor_position;

    // Screen mirror and cursor of the predictor
    logic [15:0] screen_mirror [CELLS];
    int unsigned mirror_col;
    int unsigned mirror_row;
    logic [7:0]  mirror_attr;

    t_term_result pending_results [$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_req  = 0;
    int items_sent;
    int results_checked;
    int scroll_count;
    int error_count;

    text_terminal_char_writer_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_action          (i_action),
        .i_char_code       (i_char_code),
        .i_read_column     (i_read_column),
        .i_read_row        (i_read_row),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_cell_value      (o_cell_value),
        .o_cursor_column   (o_cursor_column),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_position (o_cursor_position)
    );

    always #5 i_clk = ~i_clk;

    // Bound the run
    initial begin
        #15_000_000;
        $display("Regression FAIL");
        $display("timeout with %0d results outstanding", pending_results.size());
        $finish;
    end

    // Predictor: cursor moves to the next row, scrolling when past the last one
    function automatic void mirror_next_row();
        mirror_col = 0;
        mirror_row++;
        if (mirror_row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                screen_mirror[i] = screen_mirror[i + COLUMNS];
            for (int j = 0; j < COLUMNS; j++)
                screen_mirror[(ROWS - 1) * COLUMNS + j] = {mirror_attr, BLANK_CHAR};
            mirror_row = ROWS - 1;
            scroll_count++;
        end
    endfunction

    function automatic t_term_result predict_terminal(logic act, logic [7:0] ch,
                                                      logic [6:0] rc, logic [4:0] rr);
        t_term_result res;
        int unsigned  lin;
        res.cell_value = 16'h0000;
        if (act == ACT_READ) begin
            if (rc < COLUMNS && rr < ROWS)
                res.cell_value = screen_mirror[rr * COLUMNS + rc];
        end else if (ch == NEWLINE_CODE) begin
            mirror_next_row();
        end else begin
            screen_mirror[mirror_row * COLUMNS + mirror_col] = {mirror_attr, ch};
            mirror_col++;
            if (mirror_col >= COLUMNS)
                mirror_next_row();
        end
        lin                 = mirror_row * COLUMNS + mirror_col;
        res.cursor_column   = mirror_col[6:0];
        res.cursor_row      = mirror_row[4:0];
        res.cursor_position = lin[10:0];
        return res;
    endfunction

    function automatic void reset_mirror();
        for (int i = 0; i < CELLS; i++)
            screen_mirror[i] = RESET_CELL;
        mirror_col  = 0;
        mirror_row  = 0;
        mirror_attr = ATTR_RESET;
    endfunction

    // Receiver: random stalls, plus a long hold-off when requested
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_term_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: cell_value %h cursor %0d,%0d", o_cell_value,
                       o_cursor_row, o_cursor_column);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                results_checked++;
                if (o_cell_value !== exp_res.cell_value) begin
                    $error("cell_value mismatch: expected %h, actual %h",
                           exp_res.cell_value, o_cell_value);
                    error_count++;
                end
                if (o_cursor_column !== exp_res.cursor_column) begin
                    $error("cursor_column mismatch: expected %0d, actual %0d",
                           exp_res.cursor_column, o_cursor_column);
                    error_count++;
                end
                if (o_cursor_row !== exp_res.cursor_row) begin
                    $error("cursor_row mismatch: expected %0d, actual %0d",
                           exp_res.cursor_row, o_cursor_row);
                    error_count++;
                end
                if (o_cursor_position !== exp_res.cursor_position) begin
                    $error("cursor_position mismatch: expected %0d, actual %0d",
                           exp_res.cursor_position, o_cursor_position);
                    error_count++;
                end
            end
        end
    end

    // Offer one transaction; called and returns at a falling edge
    task automatic send_item(input logic act, input logic [7:0] ch,
                             input logic [6:0] rc, input logic [4:0] rr);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_char_code   <= ch;
        i_read_column <= rc;
        i_read_row    <= rr;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pending_results.push_back(predict_terminal(act, ch, rc, rr));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_item(ACT_PUT, ch, 7'($urandom_range(127)), 5'($urandom_range(31)));
    endtask

    task automatic read_cell(input logic [6:0] rc, input logic [4:0] rr);
        send_item(ACT_READ, 8'($urandom_range(255)), rc, rr);
    endtask

    // Drop valid, wait for all results and for any scroll to finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_attr(input logic [7:0] attr);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= attr;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        mirror_attr = attr;
    endtask

    // Fresh screen holds blanks; reads outside the screen return zero
    task automatic test_reset_screen();
        read_cell(7'd0, 5'd0);
        read_cell(7'(COLUMNS - 1), 5'(ROWS - 1));
        read_cell(7'(COLUMNS - 1), 5'd0);
        read_cell(7'd0, 5'(ROWS - 1));
        read_cell(7'(COLUMNS), 5'd0);
        read_cell(7'd0, 5'(ROWS));
        read_cell(7'd127, 5'd31);
        settle();
    endtask

    // Character extremes, newline and read-back of what was written
    task automatic test_put_basics();
        write_attr(8'h1E);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(NEWLINE_CODE);
        put_char(8'h7F);
        read_cell(7'd0, 5'd0);
        read_cell(7'd1, 5'd0);
        read_cell(7'd2, 5'd0);
        read_cell(7'd3, 5'd0);
        read_cell(7'd0, 5'd1);
        read_cell(7'd127, 5'd1);
        settle();
    endtask

    // Newlines down the screen until it scrolls; check the blanked last row
    task automatic test_scroll();
        write_attr(8'hA5);
        while (mirror_row < ROWS - 1)
            put_char(NEWLINE_CODE);
        put_char(8'h5A);
        put_char(NEWLINE_CODE);
        read_cell(7'd0, 5'(ROWS - 1));
        read_cell(7'd0, 5'(ROWS - 2));
        read_cell(7'(COLUMNS - 1), 5'(ROWS - 1));
        read_cell(7'd0, 5'd0);
        settle();
    endtask

    // One random transaction, weighted toward puts that fill and scroll the screen
    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            put_char(8'($urandom_range(255)));
        else if (pick < 63)
            put_char(NEWLINE_CODE);
        else if (pick < 93)
            read_cell(7'($urandom_range(COLUMNS - 1)), 5'($urandom_range(ROWS - 1)));
        else
            read_cell(7'($urandom_range(127)), 5'($urandom_range(31)));
    endtask

    // Random traffic in phases of sender idling and receiver stalls, with an attribute change per phase
    task automatic test_random_phases();
        int phase_idle  [4] = '{0, 71, 0, 6};
        int phase_stall [4] = '{0, 0, 71, 6};
        logic [7:0] phase_attr [4];
        phase_attr = '{8'h00, 8'hFF, 8'($urandom_range(255)), ATTR_RESET};
        for (int p = 0; p < 4; p++) begin
            write_attr(phase_attr[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            repeat (60) begin
                random_item();
                if ($urandom_range(3) == 0) begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    repeat (10) random_item();
                    idle_pct  = phase_idle[p];
                    stall_pct = phase_stall[p];
                end
            end
            repeat (90) random_item();
            settle();
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // Hold the receiver off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        @(posedge i_clk);
        hold_req = 400;
        @(negedge i_clk);
        repeat (40) random_item();
        settle();
    endtask

    initial begin
        items_sent      = 0;
        results_checked = 0;
        scroll_count    = 0;
        error_count     = 0;
        reset_mirror();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_screen();
        test_put_basics();
        test_scroll();
        test_backpressure();
        test_random_phases();

        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end

        $display("Covered %0d items and %0d checked results, with %0d screen scrolls,",
                 items_sent, results_checked, scroll_count);
        $display("attribute extremes, out-of-range reads and receiver hold-off.");
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/ttcw_pkg.sv
src/ttcw_front.sv
src/ttcw_cmd_fifo.sv
src/ttcw_back.sv
src/text_terminal_char_writer_unit.sv
dv/tb_top.sv
